// File: hw/rtl/bgfm_pkg.sv
// Package for the block gradient focus measure.
// Holds widths, register reset values, register indexes and the shared structs.
// No dependencies.
package bgfm_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned LINE_DEF  = 2048;
  localparam int unsigned FW_W      = 12;
  localparam int unsigned RX_W      = 11;
  localparam int unsigned RY_W      = 12;
  localparam int unsigned RW_W      = 12;
  localparam int unsigned RH_W      = 13;
  localparam int unsigned CX_W      = 12;
  localparam int unsigned CY_W      = 13;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned AREA_W    = RW_W + RH_W;
  localparam int unsigned SQ_W      = 2 * PIX_W;
  localparam int unsigned GRAD_W    = SQ_W + 1;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_SEL_W = 3;

  localparam logic [FW_W-1:0] FW_RST = 12'd1920;
  localparam logic [RX_W-1:0] RX_RST = 11'd0;
  localparam logic [RY_W-1:0] RY_RST = 12'd0;
  localparam logic [RW_W-1:0] RW_RST = 12'd1916;
  localparam logic [RH_W-1:0] RH_RST = 13'd1076;
  localparam logic [CX_W-1:0] CX_RST = 12'd1916;
  localparam logic [CY_W-1:0] CY_RST = 13'd1076;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_FRAME_WIDTH,
    REG_ROI_X,
    REG_ROI_Y,
    REG_ROI_WIDTH,
    REG_ROI_HEIGHT,
    REG_CLIP_X_END,
    REG_CLIP_Y_END
  } reg_idx_e;

  typedef struct packed {
    logic [FW_W-1:0] frame_width;
    logic [RX_W-1:0] roi_x;
    logic [RY_W-1:0] roi_y;
    logic [RW_W-1:0] roi_width;
    logic [RH_W-1:0] roi_height;
    logic [CX_W-1:0] clip_x_end;
    logic [CY_W-1:0] clip_y_end;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] gradient;
    logic [SUM_W-1:0] energy;
  } frame_sum_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_MEAN_GO,
    RS_MEAN,
    RS_SHARP_GO,
    RS_SHARP,
    RS_OUT
  } res_state_e;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: hw/rtl/bgfm_if.sv
// Stream interfaces of the block gradient focus measure: pixel words in, result words out.
// Depends on bgfm_pkg.
interface bgfm_pix_if;
  import bgfm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  logic             frame_end;
  modport source(output valid, pixel, frame_start, frame_end, input ready);
  modport sink(input valid, pixel, frame_start, frame_end, output ready);
endinterface

interface bgfm_res_if;
  import bgfm_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sharpness;
  logic             divide_error;
  modport source(output valid, sharpness, divide_error, input ready);
  modport sink(input valid, sharpness, divide_error, output ready);
endinterface

// File: hw/rtl/block_gradient_focus_measure.sv
// Block gradient focus measure, top level with the register file.
// Pixel words are taken one per cycle while not held off; a frame_end word holds off input until
// the end-of-frame computation is done and its result word has been loaded.
// Reset clears position, sums, control and registers; the line store keeps no reset.
// Depends on bgfm_pkg, bgfm_if, bgfm_pixel_path, bgfm_div and bgfm_result.
module block_gradient_focus_measure #(
  parameter int unsigned MaxLine = bgfm_pkg::LINE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bgfm_pix_if.sink                      pix,
  bgfm_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgfm_pkg::PADDR_W-1:0]  paddr,
  input  logic [bgfm_pkg::PDATA_W-1:0]  pwdata,
  output logic [bgfm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import bgfm_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   reg_sel;
  frame_sum_t sums;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       hold, busy, accept;

  assign reg_sel = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign accept  = pix.valid && pix.ready;
  assign pix.ready = !hold && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width <= FW_RST;
      cfg_q.roi_x       <= RX_RST;
      cfg_q.roi_y       <= RY_RST;
      cfg_q.roi_width   <= RW_RST;
      cfg_q.roi_height  <= RH_RST;
      cfg_q.clip_x_end  <= CX_RST;
      cfg_q.clip_y_end  <= CY_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[FW_W-1:0];
        REG_ROI_X:       cfg_q.roi_x       <= pwdata[RX_W-1:0];
        REG_ROI_Y:       cfg_q.roi_y       <= pwdata[RY_W-1:0];
        REG_ROI_WIDTH:   cfg_q.roi_width   <= pwdata[RW_W-1:0];
        REG_ROI_HEIGHT:  cfg_q.roi_height  <= pwdata[RH_W-1:0];
        REG_CLIP_X_END:  cfg_q.clip_x_end  <= pwdata[CX_W-1:0];
        REG_CLIP_Y_END:  cfg_q.clip_y_end  <= pwdata[CY_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH: prdata = PDATA_W'(cfg_q.frame_width);
      REG_ROI_X:       prdata = PDATA_W'(cfg_q.roi_x);
      REG_ROI_Y:       prdata = PDATA_W'(cfg_q.roi_y);
      REG_ROI_WIDTH:   prdata = PDATA_W'(cfg_q.roi_width);
      REG_ROI_HEIGHT:  prdata = PDATA_W'(cfg_q.roi_height);
      REG_CLIP_X_END:  prdata = PDATA_W'(cfg_q.clip_x_end);
      REG_CLIP_Y_END:  prdata = PDATA_W'(cfg_q.clip_y_end);
      default:         prdata = '0;
    endcase
  end

  bgfm_pixel_path #(
    .MaxLine(MaxLine)
  ) u_pixel_path (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (pix.pixel),
    .frame_start_i(pix.frame_start),
    .frame_end_i  (pix.frame_end),
    .cfg_i        (cfg_q),
    .sums_o       (sums),
    .hold_o       (hold)
  );

  bgfm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  bgfm_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sums_i      (sums),
    .roi_width_i (cfg_q.roi_width),
    .roi_height_i(cfg_q.roi_height),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .busy_o      (busy),
    .res         (res)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid && pix.ready && pix.frame_end |=> !pix.ready)
    else $error("input taken right after a frame end word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.divide_error |-> res.sharpness == '0)
    else $error("divide error word carries a nonzero sharpness");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res.valid) |-> $past(busy))
    else $error("result word appeared without a frame computation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res.valid)
    else $error("frame computation ended without loading a result word");

endmodule

// File: hw/rtl/bgfm_pixel_path.sv
// Two-stage pixel path around the line store memory: position and block tracking,
// then squared differences and saturating frame sums. Depends on bgfm_pkg.
module bgfm_pixel_path #(
  parameter int unsigned MaxLine = bgfm_pkg::LINE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [bgfm_pkg::PIX_W-1:0]  pixel_i,
  input  logic                        frame_start_i,
  input  logic                        frame_end_i,
  input  bgfm_pkg::cfg_t              cfg_i,
  output bgfm_pkg::frame_sum_t        sums_o,
  output logic                        hold_o
);
  import bgfm_pkg::*;

  localparam int unsigned AW = $clog2(MaxLine);
  localparam int unsigned CW = AW + 1;

  logic [PIX_W-1:0] line_mem [MaxLine];
  logic [PIX_W-1:0] rdat_q;

  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] left_q;

  logic [AW-1:0]    col0;
  logic [ROW_W-1:0] row0;
  logic [PIX_W-1:0] left0;
  logic [CW-1:0]    eff, col_nxt;
  logic [POS_W-1:0] colx, rowx, rx, ry, ox, oy, bx, by, ex_raw, ey_raw, ex, ey;
  logic             in_blk, vert, horz;
  logic [1:0]       dx, dy;

  logic             v1_q, fs1_q, fe1_q, in1_q, vert1_q, horz1_q, fwd1_q;
  logic [PIX_W-1:0] p1_q, left1_q, fdat1_q;
  logic [AW-1:0]    col1_q;

  logic [PIX_W-1:0] up;
  logic [SQ_W-1:0]  sq_v, sq_h, sq_e;
  logic [GRAD_W-1:0] g_add;
  logic [SUM_W-1:0] g_q, e_q, g_base, e_base, g_sat, e_sat;
  logic [SUM_W:0]   g_sum, e_sum;

  always_comb begin
    if (cfg_i.frame_width == '0 || 32'(cfg_i.frame_width) > MaxLine) begin
      eff = CW'(MaxLine);
    end else begin
      eff = CW'(cfg_i.frame_width);
    end
    col0    = frame_start_i ? '0 : col_q;
    row0    = frame_start_i ? '0 : row_q;
    left0   = frame_start_i ? '0 : left_q;
    col_nxt = {1'b0, col0} + CW'(1);

    colx   = POS_W'(col0);
    rowx   = POS_W'(row0);
    rx     = POS_W'(cfg_i.roi_x);
    ry     = POS_W'(cfg_i.roi_y);
    ox     = colx - rx;
    oy     = rowx - ry;
    bx     = rx + {ox[POS_W-1:2], 2'b00};
    by     = ry + {oy[POS_W-1:2], 2'b00};
    ex_raw = rx + POS_W'(cfg_i.roi_width);
    ey_raw = ry + POS_W'(cfg_i.roi_height);
    ex     = (ex_raw > POS_W'(cfg_i.clip_x_end)) ? POS_W'(cfg_i.clip_x_end) : ex_raw;
    ey     = (ey_raw > POS_W'(cfg_i.clip_y_end)) ? POS_W'(cfg_i.clip_y_end) : ey_raw;
    dx     = ox[1:0];
    dy     = oy[1:0];
    in_blk = (colx >= rx) && (rowx >= ry) && (bx < ex) && (by < ey);
    vert   = in_blk && ((dy == 2'd1 && dx <= 2'd1) || (dy == 2'd3 && dx >= 2'd2));
    horz   = in_blk && ((dx == 2'd3 && dy <= 2'd1) || (dx == 2'd1 && dy >= 2'd2));

    if (frame_end_i) begin
      col_d = '0;
      row_d = '0;
    end else if (col_nxt >= eff) begin
      col_d = '0;
      row_d = row0 + ROW_W'(1);
    end else begin
      col_d = col_nxt[AW-1:0];
      row_d = row0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdat_q <= line_mem[col0];
    end
    if (v1_q) begin
      line_mem[col1_q] <= p1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      v1_q   <= 1'b0;
      fs1_q  <= 1'b0;
      fe1_q  <= 1'b0;
    end else begin
      v1_q <= accept_i;
      if (accept_i) begin
        col_q  <= col_d;
        row_q  <= row_d;
        left_q <= pixel_i;
        fs1_q  <= frame_start_i;
        fe1_q  <= frame_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p1_q    <= pixel_i;
      left1_q <= left0;
      col1_q  <= col0;
      in1_q   <= in_blk;
      vert1_q <= vert;
      horz1_q <= horz;
      fwd1_q  <= v1_q && (col1_q == col0);
      fdat1_q <= p1_q;
    end
  end

  always_comb begin
    up     = fwd1_q ? fdat1_q : rdat_q;
    sq_v   = SQ_W'(abs_diff(up, p1_q)) * SQ_W'(abs_diff(up, p1_q));
    sq_h   = SQ_W'(abs_diff(left1_q, p1_q)) * SQ_W'(abs_diff(left1_q, p1_q));
    sq_e   = SQ_W'(p1_q) * SQ_W'(p1_q);
    g_add  = (vert1_q ? GRAD_W'(sq_v) : '0) + (horz1_q ? GRAD_W'(sq_h) : '0);
    g_base = fs1_q ? '0 : g_q;
    e_base = fs1_q ? '0 : e_q;
    g_sum  = {1'b0, g_base} + (SUM_W + 1)'(g_add);
    e_sum  = {1'b0, e_base} + (in1_q ? (SUM_W + 1)'(sq_e) : '0);
    g_sat  = g_sum[SUM_W] ? '1 : g_sum[SUM_W-1:0];
    e_sat  = e_sum[SUM_W] ? '1 : e_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
      e_q <= '0;
    end else if (v1_q) begin
      g_q <= fe1_q ? '0 : g_sat;
      e_q <= fe1_q ? '0 : e_sat;
    end
  end

  assign sums_o.valid    = v1_q && fe1_q;
  assign sums_o.gradient = g_sat;
  assign sums_o.energy   = e_sat;
  assign hold_o          = v1_q && fe1_q;

endmodule

// File: hw/rtl/bgfm_div.sv
// Restoring divider that yields one quotient bit per cycle.
// Shared by both end-of-frame quotients. Depends on bgfm_pkg.
module bgfm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bgfm_pkg::div_req_t req_i,
  output bgfm_pkg::div_rsp_t rsp_o
);
  import bgfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] rem_q, quo_q, dvs_q, rem_n, quo_n;
  logic [SUM_W:0]   rem_sh;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q, ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_n  = ge ? SUM_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[SUM_W-1:0];
    quo_n  = {quo_q[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(SUM_W);
    end else if (run_q) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      run_q  <= (cnt_q != CNT_W'(1));
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: hw/rtl/bgfm_result.sv
// End-of-frame sequencer: area product, mean energy, sharpness quotient and result register.
// Depends on bgfm_pkg and bgfm_res_if.
module bgfm_result (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bgfm_pkg::frame_sum_t       sums_i,
  input  logic [bgfm_pkg::RW_W-1:0]  roi_width_i,
  input  logic [bgfm_pkg::RH_W-1:0]  roi_height_i,
  output bgfm_pkg::div_req_t         div_req_o,
  input  bgfm_pkg::div_rsp_t         div_rsp_i,
  output logic                       busy_o,
  bgfm_res_if.source                 res
);
  import bgfm_pkg::*;

  res_state_e        state_q, state_d;
  logic [SUM_W-1:0]  grad_q, energy_q, mean_q, sharp_q, out_sharp_q;
  logic [AREA_W-1:0] area_q;
  logic              err_q, out_err_q, out_valid_q, load_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RS_IDLE:     if (sums_i.valid) state_d = RS_MEAN_GO;
      RS_MEAN_GO:  state_d = (area_q == '0) ? RS_OUT : RS_MEAN;
      RS_MEAN:     if (div_rsp_i.done) state_d = RS_SHARP_GO;
      RS_SHARP_GO: state_d = (mean_q == '0) ? RS_OUT : RS_SHARP;
      RS_SHARP:    if (div_rsp_i.done) state_d = RS_OUT;
      RS_OUT:      if (!out_valid_q || res.ready) state_d = RS_IDLE;
      default:     state_d = RS_IDLE;
    endcase
  end

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = energy_q;
    div_req_o.divisor  = SUM_W'(area_q);
    load_out           = 1'b0;
    unique case (state_q)
      RS_MEAN_GO:  div_req_o.start = (area_q != '0);
      RS_SHARP_GO: begin
        div_req_o.start    = (mean_q != '0);
        div_req_o.dividend = grad_q;
        div_req_o.divisor  = mean_q;
      end
      RS_OUT:      load_out = !out_valid_q || res.ready;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == RS_IDLE && sums_i.valid) begin
      grad_q   <= sums_i.gradient;
      energy_q <= sums_i.energy;
      area_q   <= AREA_W'(roi_width_i) * AREA_W'(roi_height_i);
    end
    if (state_q == RS_MEAN_GO && area_q == '0) begin
      sharp_q <= '0;
      err_q   <= 1'b1;
    end
    if (state_q == RS_MEAN && div_rsp_i.done) begin
      mean_q <= div_rsp_i.quotient;
    end
    if (state_q == RS_SHARP_GO && mean_q == '0) begin
      sharp_q <= '0;
      err_q   <= 1'b1;
    end
    if (state_q == RS_SHARP && div_rsp_i.done) begin
      sharp_q <= div_rsp_i.quotient;
      err_q   <= 1'b0;
    end
    if (load_out) begin
      out_sharp_q <= sharp_q;
      out_err_q   <= err_q;
    end
  end

  assign busy_o           = (state_q != RS_IDLE);
  assign res.valid        = out_valid_q;
  assign res.sharpness    = out_sharp_q;
  assign res.divide_error = out_err_q;

endmodule

// File: verif/tb_block_gradient_focus_measure.sv
`timescale 1ns / 100ps
// Testbench for block_gradient_focus_measure: streams pixel words over many region, clip
// and frame width settings, and checks each result word against a cycle-free model.
// Depends on bgfm_pkg, bgfm_if and the block's RTL.
module tb_block_gradient_focus_measure;
  import bgfm_pkg::*;

  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned IDLE_PCT = 24;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned MIN_FRAMES = 16;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

  typedef enum int unsigned {
    PM_UNIFORM,
    PM_LOW,
    PM_EXTREME,
    PM_FLAT
  } pix_mode_e;

  typedef struct packed {
    logic [SUM_W-1:0] sharpness;
    logic             divide_error;
  } focus_result_t;

  class focus_scoreboard;
    cfg_t             cfg;
    logic [PIX_W-1:0] line_mem [LINE_DEF];
    logic [PIX_W-1:0] left_pix;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    longint unsigned  grad_acc;
    longint unsigned  energy_acc;
    focus_result_t    expected_q[$];
    int unsigned      mismatches;

    function new();
      cfg.frame_width = FW_RST;
      cfg.roi_x = RX_RST;
      cfg.roi_y = RY_RST;
      cfg.roi_width = RW_RST;
      cfg.roi_height = RH_RST;
      cfg.clip_x_end = CX_RST;
      cfg.clip_y_end = CY_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      left_pix = '0;
      mismatches = 0;
      clear_frame_state();
    endfunction

    function void clear_frame_state();
      col_cnt = 0;
      row_cnt = 0;
      grad_acc = 0;
      energy_acc = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: cfg.frame_width = val[FW_W-1:0];
        REG_ROI_X:       cfg.roi_x = val[RX_W-1:0];
        REG_ROI_Y:       cfg.roi_y = val[RY_W-1:0];
        REG_ROI_WIDTH:   cfg.roi_width = val[RW_W-1:0];
        REG_ROI_HEIGHT:  cfg.roi_height = val[RH_W-1:0];
        REG_CLIP_X_END:  cfg.clip_x_end = val[CX_W-1:0];
        REG_CLIP_Y_END:  cfg.clip_y_end = val[CY_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > SUM_MAX) ? SUM_MAX : s;
    endfunction

    function longint unsigned sq_diff(int unsigned a, int unsigned b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    // Updates position, line memory and sums for one accepted pixel word; a frame end
    // word queues the result word the block must produce.
    function void take_pixel(logic [PIX_W-1:0] pix_v, logic fs, logic fe);
      int unsigned     line_len, col, row, dx, dy, end_x, end_y;
      longint unsigned step_grad, area, mean;
      focus_result_t   res_v;
      line_len = cfg.frame_width;
      if (line_len == 0 || line_len > LINE_DEF) line_len = LINE_DEF;
      if (fs) begin
        clear_frame_state();
        left_pix = '0;
      end
      col = col_cnt;
      row = row_cnt;
      if (col >= LINE_DEF) col = 0;
      end_x = cfg.roi_x;
      end_x = end_x + cfg.roi_width;
      if (end_x > cfg.clip_x_end) end_x = cfg.clip_x_end;
      end_y = cfg.roi_y;
      end_y = end_y + cfg.roi_height;
      if (end_y > cfg.clip_y_end) end_y = cfg.clip_y_end;
      if (col >= cfg.roi_x && row >= cfg.roi_y) begin
        dx = (col - cfg.roi_x) & 3;
        dy = (row - cfg.roi_y) & 3;
        if (col - dx < end_x && row - dy < end_y) begin
          energy_acc = sat_add(energy_acc, sq_diff(pix_v, 0));
          step_grad = 0;
          if ((dy == 1 && dx <= 1) || (dy == 3 && dx >= 2))
            step_grad += sq_diff(line_mem[col], pix_v);
          if ((dx == 3 && dy <= 1) || (dx == 1 && dy >= 2))
            step_grad += sq_diff(left_pix, pix_v);
          grad_acc = sat_add(grad_acc, step_grad);
        end
      end
      line_mem[col] = pix_v;
      left_pix = pix_v;
      if (col + 1 >= line_len) begin
        col_cnt = 0;
        row_cnt = (row + 1) % (1 << ROW_W);
      end else begin
        col_cnt = col + 1;
      end
      if (fe) begin
        area = cfg.roi_width;
        area = area * cfg.roi_height;
        mean = (area != 0) ? energy_acc / area : 0;
        if (mean == 0) begin
          res_v.sharpness = '0;
          res_v.divide_error = 1'b1;
        end else begin
          res_v.sharpness = SUM_W'(grad_acc / mean);
          res_v.divide_error = 1'b0;
        end
        expected_q.push_back(res_v);
        clear_frame_state();
      end
    endfunction

    function void check_result(logic [SUM_W-1:0] sharp, logic derr);
      focus_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no frame pending: sharpness %0d divide_error %0b",
               sharp, derr);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (sharp !== want.sharpness) begin
        $error("sharpness: expected %0d, actual %0d", want.sharpness, sharp);
        mismatches++;
      end
      if (derr !== want.divide_error) begin
        $error("divide_error: expected %0b, actual %0b", want.divide_error, derr);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  bit                   no_gaps;
  int unsigned          stall_cycles;
  focus_scoreboard      sb = new();

  bgfm_pix_if pix_bus ();
  bgfm_res_if res_bus ();

  block_gradient_focus_measure u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix     (pix_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < IDLE_PCT);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= !take_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles = stall_cycles + 1;
      if (pix_bus.valid && pix_bus.ready) begin
        sb.take_pixel(pix_bus.pixel, pix_bus.frame_start, pix_bus.frame_end);
        stall_cycles = 0;
      end
      if (res_bus.valid && res_bus.ready) begin
        sb.check_result(res_bus.sharpness, res_bus.divide_error);
        stall_cycles = 0;
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input int unsigned fw, input int unsigned rx, input int unsigned ry,
                            input int unsigned rw, input int unsigned rh,
                            input int unsigned cx, input int unsigned cy);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_ROI_X, rx);
    write_reg(REG_ROI_Y, ry);
    write_reg(REG_ROI_WIDTH, rw);
    write_reg(REG_ROI_HEIGHT, rh);
    write_reg(REG_CLIP_X_END, cx);
    write_reg(REG_CLIP_Y_END, cy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix_v, input logic fs, input logic fe);
    while (take_gap()) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= pix_v;
    pix_bus.frame_start <= fs;
    pix_bus.frame_end <= fe;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
  endtask

  // Waits until every frame end word has produced its result word and the block is idle.
  task automatic settle();
    pix_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(pix_mode_e mode, logic [PIX_W-1:0] flat);
    case (mode)
      PM_LOW:     return PIX_W'($urandom_range(3));
      PM_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      PM_FLAT:    return flat;
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  // Short frames now and then restart in the middle with a stray frame start.
  task automatic send_frame(input int unsigned n_pix, input bit with_start, input bit with_end,
                            input pix_mode_e mode);
    logic [PIX_W-1:0] flat;
    int unsigned      restart_at;
    flat = PIX_W'($urandom);
    restart_at = n_pix;
    if (n_pix < 200 && $urandom_range(9) == 0) restart_at = $urandom_range(n_pix - 1);
    for (int unsigned k = 0; k < n_pix; k++) begin
      send_pixel(pick_pixel(mode, flat), (with_start && k == 0) || k == restart_at,
                 with_end && k == n_pix - 1);
    end
  endtask

  initial begin
    int unsigned fw, rx, ry, rw, rh, cx, cy;
    int unsigned n_pix, n_frames, items, frames_done;
    bit          with_start, with_end;
    pix_mode_e   mode;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel = '0;
    pix_bus.frame_start = 1'b0;
    pix_bus.frame_end = 1'b0;
    no_gaps = 1'b0;
    stall_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values and no frame start: the area is large, so the mean is zero.
    send_pixel(8'hFF, 1'b0, 1'b0);
    send_pixel(8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 1'b0, 1'b1);
    settle();

    // One full block of a checkerboard with extreme values.
    set_config(4, 0, 0, 4, 4, 4, 4);
    for (int k = 0; k < 16; k++) begin
      send_pixel(((k + k / 4) % 2) ? 8'hFF : 8'h00, k == 0, k == 15);
    end
    settle();

    // Zero region area, with frame start and frame end on the same word.
    set_config(4, 0, 0, 0, 4, 4, 4);
    send_pixel(8'h80, 1'b1, 1'b1);
    settle();

    // Region start beyond the clip end: no block is taken.
    set_config(4, 3, 0, 4, 4, 2, 4);
    for (int k = 0; k < 4; k++) send_pixel(PIX_W'($urandom), k == 0, k == 3);
    settle();

    // A frame width of zero acts as the full line, so a short frame stays in its first row.
    set_config(0, 0, 0, 8, 1, 2048, 4);
    send_frame(24, 1'b1, 1'b1, PM_UNIFORM);
    settle();

    // A frame width above the line size, with the widest region width and x clip value.
    set_config(4095, 0, 0, 4095, 1, 4095, 1);
    send_frame(24, 1'b1, 1'b1, PM_UNIFORM);
    settle();

    items = 0;
    frames_done = 0;
    while (items < RANDOM_ITEMS || frames_done < MIN_FRAMES) begin
      fw = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(4, 8);
      rx = ($urandom_range(7) == 0) ? $urandom_range(fw + 2) : $urandom_range(fw - 1);
      ry = $urandom_range(3);
      rw = $urandom_range(1, fw);
      rh = $urandom_range(1, 6);
      cx = $urandom_range(1) ? 2048 : $urandom_range(1, rx + rw + 2);
      cy = $urandom_range(1) ? 4096 : $urandom_range(1, ry + rh + 2);
      set_config(fw, rx, ry, rw, rh, cx, cy);
      n_frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < n_frames; f++) begin
        no_gaps = (frames_done >= 6 && frames_done < 12);
        n_pix = (ry + rh + $urandom_range(2)) * fw;
        if ($urandom_range(3) == 0) n_pix = n_pix - $urandom_range(1, fw);
        if (n_pix == 0) n_pix = 1;
        with_start = (f == 0) || ($urandom_range(4) != 0);
        with_end = ($urandom_range(9) != 0);
        mode = ($urandom_range(9) < 6) ? PM_UNIFORM : pix_mode_e'($urandom_range(1, 3));
        send_frame(n_pix, with_start, with_end, mode);
        items += n_pix;
        if (with_end) frames_done++;
      end
      settle();
    end
    no_gaps = 1'b0;
    settle();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bgfm_pkg.sv
hw/rtl/bgfm_if.sv
hw/rtl/bgfm_pixel_path.sv
hw/rtl/bgfm_div.sv
hw/rtl/bgfm_result.sv
hw/rtl/block_gradient_focus_measure.sv
verif/tb_block_gradient_focus_measure.sv
